/* design/linear_array_queue_with_search_macros.svh */
// Assertion macros for the queue RTL.
`ifndef LINEAR_ARRAY_QUEUE_WITH_SEARCH_MACROS_SVH
`define LINEAR_ARRAY_QUEUE_WITH_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define LAQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("queue assertion failed");
// Next-cycle implication, disabled during reset.
`define LAQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("queue assertion failed");
`else
`define LAQS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LAQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/laqs_pkg.sv */
// Types and constants of the linear array queue with search.
package laqs_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int REQ_W  = 3;
	localparam int ST_W   = 3;

	localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LIST = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FIND = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DUP  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_NODUP    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_RD,
		S_POP_DONE,
		S_LIST_RD,
		S_LIST,
		S_FIND_RD,
		S_FIND,
		S_DUP_RDI,
		S_DUP_LDI,
		S_DUP_RDJ,
		S_DUP_CMP,
		S_DUP_END
	} state_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_PUSH,
		A_OVERFLOW,
		A_EMPTY,
		A_POP_LAST,
		A_POP_ADV,
		A_POP_DONE,
		A_SCAN_INIT,
		A_LIST,
		A_FIND_HIT,
		A_FIND_MISS,
		A_NEXT_I,
		A_LOAD_CAND,
		A_NEXT_J,
		A_DUP_HIT,
		A_DUP_END
	} act_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_J,
		RD_HEAD
	} rd_src_t;

	// Sequencer command to the datapath
	typedef struct packed {
		logic    busy;
		rd_src_t rd_src;
		act_t    act;
	} ctl_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic holds;
		logic full;
		logic single;
		logic i_at_tail;
		logic i_at_head;
		logic j_last;
		logic match;
		logic dup_match;
	} sts_t;

endpackage

/* design/laqs_ctrl.sv */
// Sequencer of the queue: walks slots one read at a time and issues datapath actions.
module laqs_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [laqs_pkg::REQ_W-1:0]  req_type,
	input  laqs_pkg::sts_t              sts,
	output laqs_pkg::ctl_t              ctl
);

	laqs_pkg::state_t state_q;
	laqs_pkg::state_t state_nxt;
	logic             accept;

	assign accept = start && (state_q == laqs_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= laqs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			laqs_pkg::S_IDLE: begin
				if (accept && sts.holds) begin
					unique case (req_type)
						laqs_pkg::REQ_POP: begin
							if (!sts.single) begin
								state_nxt = laqs_pkg::S_POP_RD;
							end
						end
						laqs_pkg::REQ_LIST: state_nxt = laqs_pkg::S_LIST_RD;
						laqs_pkg::REQ_FIND: state_nxt = laqs_pkg::S_FIND_RD;
						laqs_pkg::REQ_DUP:  state_nxt = laqs_pkg::S_DUP_RDI;
						default:            state_nxt = laqs_pkg::S_IDLE;
					endcase
				end
			end
			laqs_pkg::S_POP_RD:   state_nxt = laqs_pkg::S_POP_DONE;
			laqs_pkg::S_POP_DONE: state_nxt = laqs_pkg::S_IDLE;
			laqs_pkg::S_LIST_RD:  state_nxt = laqs_pkg::S_LIST;
			laqs_pkg::S_LIST: begin
				state_nxt = sts.i_at_tail ? laqs_pkg::S_IDLE : laqs_pkg::S_LIST_RD;
			end
			laqs_pkg::S_FIND_RD:  state_nxt = laqs_pkg::S_FIND;
			laqs_pkg::S_FIND: begin
				if (sts.match || sts.i_at_tail) begin
					state_nxt = laqs_pkg::S_IDLE;
				end else begin
					state_nxt = laqs_pkg::S_FIND_RD;
				end
			end
			laqs_pkg::S_DUP_RDI:  state_nxt = laqs_pkg::S_DUP_LDI;
			laqs_pkg::S_DUP_LDI: begin
				priority if (!sts.i_at_head) begin
					state_nxt = laqs_pkg::S_DUP_RDJ;
				end else if (sts.i_at_tail) begin
					state_nxt = laqs_pkg::S_DUP_END;
				end else begin
					state_nxt = laqs_pkg::S_DUP_RDI;
				end
			end
			laqs_pkg::S_DUP_RDJ:  state_nxt = laqs_pkg::S_DUP_CMP;
			laqs_pkg::S_DUP_CMP: begin
				priority if (sts.dup_match || sts.j_last) begin
					state_nxt = sts.i_at_tail ? laqs_pkg::S_DUP_END : laqs_pkg::S_DUP_RDI;
				end else begin
					state_nxt = laqs_pkg::S_DUP_RDJ;
				end
			end
			laqs_pkg::S_DUP_END:  state_nxt = laqs_pkg::S_IDLE;
			default:              state_nxt = laqs_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl.busy   = (state_q != laqs_pkg::S_IDLE);
		ctl.rd_src = laqs_pkg::RD_I;
		ctl.act    = laqs_pkg::A_NONE;
		unique case (state_q)
			laqs_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						laqs_pkg::REQ_PUSH: begin
							ctl.act = sts.full ? laqs_pkg::A_OVERFLOW : laqs_pkg::A_PUSH;
						end
						laqs_pkg::REQ_POP: begin
							priority if (!sts.holds) begin
								ctl.act = laqs_pkg::A_EMPTY;
							end else if (sts.single) begin
								ctl.act = laqs_pkg::A_POP_LAST;
							end else begin
								ctl.act = laqs_pkg::A_POP_ADV;
							end
						end
						laqs_pkg::REQ_LIST, laqs_pkg::REQ_FIND, laqs_pkg::REQ_DUP: begin
							ctl.act = sts.holds ? laqs_pkg::A_SCAN_INIT : laqs_pkg::A_EMPTY;
						end
						default: ctl.act = laqs_pkg::A_NONE;
					endcase
				end
			end
			laqs_pkg::S_POP_RD:   ctl.rd_src = laqs_pkg::RD_HEAD;
			laqs_pkg::S_POP_DONE: ctl.act = laqs_pkg::A_POP_DONE;
			laqs_pkg::S_LIST_RD:  ctl.rd_src = laqs_pkg::RD_I;
			laqs_pkg::S_LIST:     ctl.act = laqs_pkg::A_LIST;
			laqs_pkg::S_FIND_RD:  ctl.rd_src = laqs_pkg::RD_I;
			laqs_pkg::S_FIND: begin
				priority if (sts.match) begin
					ctl.act = laqs_pkg::A_FIND_HIT;
				end else if (sts.i_at_tail) begin
					ctl.act = laqs_pkg::A_FIND_MISS;
				end else begin
					ctl.act = laqs_pkg::A_NEXT_I;
				end
			end
			laqs_pkg::S_DUP_RDI:  ctl.rd_src = laqs_pkg::RD_I;
			laqs_pkg::S_DUP_LDI: begin
				priority if (!sts.i_at_head) begin
					ctl.act = laqs_pkg::A_LOAD_CAND;
				end else if (!sts.i_at_tail) begin
					ctl.act = laqs_pkg::A_NEXT_I;
				end else begin
					ctl.act = laqs_pkg::A_NONE;
				end
			end
			laqs_pkg::S_DUP_RDJ:  ctl.rd_src = laqs_pkg::RD_J;
			laqs_pkg::S_DUP_CMP: begin
				priority if (sts.dup_match) begin
					ctl.act = laqs_pkg::A_DUP_HIT;
				end else if (!sts.j_last) begin
					ctl.act = laqs_pkg::A_NEXT_J;
				end else if (!sts.i_at_tail) begin
					ctl.act = laqs_pkg::A_NEXT_I;
				end else begin
					ctl.act = laqs_pkg::A_NONE;
				end
			end
			laqs_pkg::S_DUP_END:  ctl.act = laqs_pkg::A_DUP_END;
			default:              ctl.act = laqs_pkg::A_NONE;
		endcase
	end

endmodule

/* design/linear_array_queue_with_search.sv */
// Top level of the linear array queue with search: slot memory, pointers and result registers.
//
// A request transaction is taken at a rising edge with start high and busy low; results come
// out each marked by valid for exactly one cycle, with last set on the final result of a
// request. The receiver cannot stall, so every result must be captured the cycle
// it is shown. The slot memory has a single registered read port, so slots are read one at a
// time: push, overflow and any pop or scan on an empty queue answer straight from the queue
// state, as does a pop that removes the only element; any other pop reads back the new head
// value; list reads each held element in turn; find reads slots from the head until a match
// or the tail; duplicate scan compares each element with every earlier one through the same
// port. Codes 5 to 7 are dropped without a result. Slot contents are not cleared at reset;
// only written slots are ever read.
module linear_array_queue_with_search #(
	parameter int DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [laqs_pkg::REQ_W-1:0]         req_type,
	input  logic signed [laqs_pkg::DATA_W-1:0] data,
	output logic                               valid,
	output logic signed [laqs_pkg::DATA_W-1:0] value,
	output logic [laqs_pkg::POS_W-1:0]         position,
	output logic [laqs_pkg::ST_W-1:0]          status,
	output logic                               last,
	output logic [laqs_pkg::POS_W-1:0]         occupancy,
	output logic                               is_empty,
	output logic                               is_full,
	output logic signed [laqs_pkg::DATA_W-1:0] head_value,
	output logic signed [laqs_pkg::DATA_W-1:0] tail_value
);

`include "linear_array_queue_with_search_macros.svh"

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

	// Slot memory: one write port (push), one registered read port (scans, pop)
	logic signed [laqs_pkg::DATA_W-1:0] mem [DEPTH];
	logic signed [laqs_pkg::DATA_W-1:0] rdata_q;
	logic [IW-1:0]                      rd_addr;
	logic [IW-1:0]                      wr_addr;

	// Queue state
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          holds_q;
	logic signed [laqs_pkg::DATA_W-1:0] head_val_q;
	logic signed [laqs_pkg::DATA_W-1:0] tail_val_q;

	// Scan state
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic          pend_q;
	logic signed [laqs_pkg::DATA_W-1:0] key_q;
	logic signed [laqs_pkg::DATA_W-1:0] cand_q;
	logic signed [laqs_pkg::DATA_W-1:0] pend_val_q;
	logic signed [laqs_pkg::DATA_W-1:0] popped_q;

	// Result registers
	logic                               valid_q;
	logic signed [laqs_pkg::DATA_W-1:0] value_q;
	logic [laqs_pkg::POS_W-1:0]         position_q;
	logic [laqs_pkg::ST_W-1:0]          status_q;
	logic                               last_q;

	// Result about to be registered
	logic                               emit;
	logic signed [laqs_pkg::DATA_W-1:0] e_value;
	logic [laqs_pkg::POS_W-1:0]         e_pos;
	logic [laqs_pkg::ST_W-1:0]          e_status;
	logic                               e_last;

	laqs_pkg::ctl_t ctl;
	laqs_pkg::sts_t sts;

	// Flags for the sequencer
	assign sts.holds     = holds_q;
	assign sts.full      = holds_q && (tail_q == LAST_SLOT);
	assign sts.single    = (head_q == tail_q);
	assign sts.i_at_tail = (i_q == tail_q);
	assign sts.i_at_head = (i_q == head_q);
	assign sts.j_last    = ((j_q + IW'(1)) == i_q);
	assign sts.match     = (rdata_q == key_q);
	assign sts.dup_match = (rdata_q == cand_q);

	laqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.ctl      (ctl)
	);

	assign busy = ctl.busy;

	// Pick the read address for this cycle; the read data is registered into rdata_q
	always_comb begin
		unique case (ctl.rd_src)
			laqs_pkg::RD_J:    rd_addr = j_q;
			laqs_pkg::RD_HEAD: rd_addr = head_q;
			default:           rd_addr = i_q;
		endcase
	end

	// A push into an empty queue restarts at slot 0, otherwise it lands after the tail
	assign wr_addr = holds_q ? (tail_q + IW'(1)) : '0;

	always_ff @(posedge clk) begin
		if (ctl.act == laqs_pkg::A_PUSH) begin
			mem[wr_addr] <= data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Build the result for this cycle, if any
	always_comb begin
		emit     = 1'b0;
		e_value  = '0;
		e_pos    = '0;
		e_status = laqs_pkg::ST_OK;
		e_last   = 1'b1;
		unique case (ctl.act)
			laqs_pkg::A_PUSH: emit = 1'b1;
			laqs_pkg::A_OVERFLOW: begin
				emit     = 1'b1;
				e_status = laqs_pkg::ST_OVERFLOW;
			end
			laqs_pkg::A_EMPTY: begin
				emit     = 1'b1;
				e_status = laqs_pkg::ST_EMPTY;
			end
			laqs_pkg::A_POP_LAST: begin
				emit    = 1'b1;
				e_value = head_val_q;
			end
			laqs_pkg::A_POP_DONE: begin
				emit    = 1'b1;
				e_value = popped_q;
			end
			laqs_pkg::A_LIST: begin
				emit    = 1'b1;
				e_value = rdata_q;
				e_last  = sts.i_at_tail;
			end
			laqs_pkg::A_FIND_HIT: begin
				emit  = 1'b1;
				e_pos = laqs_pkg::POS_W'(i_q) + laqs_pkg::POS_W'(1);
			end
			laqs_pkg::A_FIND_MISS: begin
				emit     = 1'b1;
				e_status = laqs_pkg::ST_NOTFOUND;
			end
			laqs_pkg::A_DUP_HIT: begin
				// Release the previous duplicate; another one follows, so it is not last
				emit    = pend_q;
				e_value = pend_val_q;
				e_last  = 1'b0;
			end
			laqs_pkg::A_DUP_END: begin
				emit = 1'b1;
				if (pend_q) begin
					e_value = pend_val_q;
				end else begin
					e_status = laqs_pkg::ST_NODUP;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	// Control state: pointers, occupancy flag, scan indices, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			holds_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			pend_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit;
			unique case (ctl.act)
				laqs_pkg::A_PUSH: begin
					if (holds_q) begin
						tail_q <= tail_q + IW'(1);
					end else begin
						head_q  <= '0;
						tail_q  <= '0;
						holds_q <= 1'b1;
					end
				end
				laqs_pkg::A_POP_LAST: begin
					// Drain: both indices return to slot 0
					holds_q <= 1'b0;
					head_q  <= '0;
					tail_q  <= '0;
				end
				laqs_pkg::A_POP_ADV: head_q <= head_q + IW'(1);
				laqs_pkg::A_SCAN_INIT: begin
					i_q    <= head_q;
					pend_q <= 1'b0;
				end
				laqs_pkg::A_LIST: begin
					if (!sts.i_at_tail) begin
						i_q <= i_q + IW'(1);
					end
				end
				laqs_pkg::A_NEXT_I:    i_q <= i_q + IW'(1);
				laqs_pkg::A_LOAD_CAND: j_q <= head_q;
				laqs_pkg::A_NEXT_J:    j_q <= j_q + IW'(1);
				laqs_pkg::A_DUP_HIT: begin
					pend_q <= 1'b1;
					if (!sts.i_at_tail) begin
						i_q <= i_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			value_q    <= e_value;
			position_q <= e_pos;
			status_q   <= e_status;
			last_q     <= e_last;
		end
		unique case (ctl.act)
			laqs_pkg::A_PUSH: begin
				tail_val_q <= data;
				if (!holds_q) begin
					head_val_q <= data;
				end
			end
			laqs_pkg::A_POP_ADV:   popped_q   <= head_val_q;
			laqs_pkg::A_POP_DONE:  head_val_q <= rdata_q;
			laqs_pkg::A_SCAN_INIT: key_q      <= data;
			laqs_pkg::A_LOAD_CAND: cand_q     <= rdata_q;
			laqs_pkg::A_DUP_HIT:   pend_val_q <= cand_q;
			default: ;
		endcase
	end

	// Result ports; queue flags are derived combinationally from the queue state registers
	assign valid      = valid_q;
	assign value      = value_q;
	assign position   = position_q;
	assign status     = status_q;
	assign last       = last_q;
	assign occupancy  = holds_q ? (laqs_pkg::POS_W'(tail_q) - laqs_pkg::POS_W'(head_q)
	                              + laqs_pkg::POS_W'(1)) : '0;
	assign is_empty   = !holds_q;
	assign is_full    = sts.full;
	assign head_value = holds_q ? head_val_q : '0;
	assign tail_value = holds_q ? tail_val_q : '0;

	// More results of the same request follow, so the block must still be busy
	`LAQS_ASSERT_IMPL(a_more_results_busy, clk, arst_n, valid_q && !last_q, busy)
	// Error and no-result statuses always end a request
	`LAQS_ASSERT_IMPL(a_err_is_last, clk, arst_n, valid_q && (status_q != laqs_pkg::ST_OK), last_q)
	// Head never passes tail while the queue holds items
	`LAQS_ASSERT_IMPL(a_head_le_tail, clk, arst_n, holds_q, head_q <= tail_q)
	// An empty queue has both indices at slot 0
	`LAQS_ASSERT_IMPL(a_empty_idx, clk, arst_n, !holds_q, (head_q == '0) && (tail_q == '0))
	// A push taken while not full leaves the queue holding items and reports a result
	`LAQS_ASSERT_NEXT(a_push_holds, clk, arst_n,
		start && !busy && (req_type == laqs_pkg::REQ_PUSH) && !sts.full, holds_q && valid_q)

endmodule
